// ----- hdl/dprm_pkg.sv -----
// Shared constants, types and value decode for the datapoint record mapper.
package dprm_pkg;

    // Table geometry and record limits
    localparam int MAP_ENTRIES     = 4;
    localparam int MAX_VALUE_BYTES = 4;
    localparam int CFG_INDEX_W     = $clog2(MAP_ENTRIES + 1);

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PARSE_ENABLE = CFG_INDEX_W'(0);
    localparam int                     REG_MAP_BASE     = 1;

    // Parser phases
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;
    localparam logic [1:0] PH_SKIP   = 2'd3;

    // Header byte positions
    localparam logic [1:0] HDR_ID     = 2'd0;
    localparam logic [1:0] HDR_TYPE   = 2'd1;
    localparam logic [1:0] HDR_LEN_HI = 2'd2;
    localparam logic [1:0] HDR_LEN_LO = 2'd3;

    // Sensor type codes
    localparam logic [7:0] SENSOR_LIMIT = 8'hF0;
    localparam logic [7:0] BUTTON_TYPE  = 8'hFE;

    // Result kinds
    localparam logic KIND_SENSOR = 1'b0;
    localparam logic KIND_BUTTON = 1'b1;

    typedef struct packed {
        logic [7:0] id;
        logic [7:0] rtype;
        logic [7:0] stype;
        logic [7:0] digits;
    } map_entry_t;

    typedef struct packed {
        logic        emit;
        logic        kind;
        logic [7:0]  stype;
        logic [31:0] value;
        logic [7:0]  digits;
        logic        button_load;
    } match_result_t;

    // Pick the value bytes that the record length calls for
    function automatic logic [31:0] decode_value(input logic [15:0] len,
                                                 input logic [31:0] acc);
        logic [31:0] val;
        val = '0;
        if (len == 16'd1) begin
            val = {24'd0, acc[7:0]};
        end else if (len == 16'd2) begin
            val = {16'd0, acc[15:0]};
        end else if (len == 16'd4) begin
            val = acc;
        end
        return val;
    endfunction

endpackage

// ----- hdl/dprm_match.sv -----
// Mapping table lookup and sensor / button decision for one completed record.
module dprm_match
    import dprm_pkg::*;
(
    input  map_entry_t [MAP_ENTRIES-1:0] entries,
    input  logic [7:0]                   rec_id,
    input  logic [7:0]                   rec_type,
    input  logic [31:0]                  value,
    input  logic [31:0]                  button_last,
    output match_result_t                result
);

    logic       done;
    logic       hit;
    map_entry_t hit_entry;

    // Walk the table in order, stop at the first zero id or first match
    always_comb
    begin
        done      = 1'b0;
        hit       = 1'b0;
        hit_entry = '0;
        for (int i = 0; i < MAP_ENTRIES; i++)
        begin
            if (!done)
            begin
                if (entries[i].id == 8'd0)
                begin
                    done = 1'b1;
                end
                else if (entries[i].id == rec_id && entries[i].rtype == rec_type)
                begin
                    done      = 1'b1;
                    hit       = 1'b1;
                    hit_entry = entries[i];
                end
            end
        end
    end

    // Decide the result for the matched entry
    always_comb
    begin
        result = '0;
        if (hit)
        begin
            if (hit_entry.stype < SENSOR_LIMIT)
            begin
                result.emit   = 1'b1;
                result.kind   = KIND_SENSOR;
                result.stype  = hit_entry.stype;
                result.value  = value;
                result.digits = hit_entry.digits;
            end
            else if (hit_entry.stype == BUTTON_TYPE && !value[31])
            begin
                // Press only on a change from a known previous value
                result.button_load = 1'b1;
                result.emit        = !button_last[31] && (button_last != value);
                result.kind        = KIND_BUTTON;
            end
        end
    end

endmodule

// ----- hdl/datapoint_record_mapper_top.sv -----
// Top level of the datapoint record mapper: byte parser, config registers, result register.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------------
//   in       | in_valid/in_ready  | data_byte[7:0], message_start
//   out      | out_valid/out_ready| event_kind, sensor_type[7:0], sensor_value[31:0],
//            |                    | decimal_digits[7:0]
//   cfg      | cfg_valid/cfg_ready| cfg_index[2:0], cfg_data[31:0]
//
// One item per cycle while in_ready is high: parse, table match and decode all sit between the parser
// state and the result register, so a result appears in the cycle after its last byte is accepted.
// in_ready drops only while a result is held and out_ready is low.
// cfg_ready is always high. Reset clears the parser, registers and result valid;
// the last button value resets to all ones (no value yet).
module datapoint_record_mapper_top
    import dprm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             data_byte,
    input  logic                   message_start,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   event_kind,
    output logic [7:0]             sensor_type,
    output logic signed [31:0]     sensor_value,
    output logic [7:0]             decimal_digits,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    logic                         parse_enable_reg;
    map_entry_t [MAP_ENTRIES-1:0] map_entry_reg;

    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  hdr_idx_reg, hdr_idx_next;
    logic [7:0]  rec_id_reg, rec_id_next;
    logic [7:0]  rec_type_reg, rec_type_next;
    logic [15:0] rec_len_reg, rec_len_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] button_last_reg;

    logic        out_valid_reg;
    logic        kind_reg;
    logic [7:0]  stype_reg;
    logic [31:0] value_reg;
    logic [7:0]  digits_reg;

    logic          in_accept;
    logic          finish;
    logic [31:0]   finish_value;
    logic [15:0]   new_len;
    match_result_t match;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign new_len   = {rec_len_reg[15:8], data_byte};

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_enable_reg <= 1'b0;
            map_entry_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_PARSE_ENABLE)
            begin
                parse_enable_reg <= cfg_data[0];
            end
            for (int i = 0; i < MAP_ENTRIES; i++)
            begin
                if (cfg_index == CFG_INDEX_W'(REG_MAP_BASE + i))
                begin
                    map_entry_reg[i] <= map_entry_t'(cfg_data);
                end
            end
        end
    end

    // Advance the parser by one byte
    always_comb
    begin
        phase_next      = phase_reg;
        hdr_idx_next    = hdr_idx_reg;
        rec_id_next     = rec_id_reg;
        rec_type_next   = rec_type_reg;
        rec_len_next    = rec_len_reg;
        bytes_left_next = bytes_left_reg;
        acc_next        = acc_reg;
        finish          = 1'b0;
        finish_value    = '0;
        if (!parse_enable_reg)
        begin
            phase_next   = PH_IDLE;
            hdr_idx_next = HDR_ID;
        end
        else if (message_start)
        begin
            // Drop any record in progress
            phase_next   = PH_HEADER;
            hdr_idx_next = HDR_ID;
        end
        else
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    unique case (hdr_idx_reg)
                        HDR_ID:
                        begin
                            rec_id_next  = data_byte;
                            hdr_idx_next = HDR_TYPE;
                        end
                        HDR_TYPE:
                        begin
                            rec_type_next = data_byte;
                            hdr_idx_next  = HDR_LEN_HI;
                        end
                        HDR_LEN_HI:
                        begin
                            rec_len_next = {data_byte, 8'd0};
                            hdr_idx_next = HDR_LEN_LO;
                        end
                        default:
                        begin
                            rec_len_next    = new_len;
                            hdr_idx_next    = HDR_ID;
                            acc_next        = '0;
                            bytes_left_next = new_len;
                            if (new_len == 16'd0)
                            begin
                                // Empty record completes right away with value zero
                                finish = 1'b1;
                            end
                            else if (new_len > 16'(MAX_VALUE_BYTES))
                            begin
                                phase_next = PH_SKIP;
                            end
                            else
                            begin
                                phase_next = PH_DATA;
                            end
                        end
                    endcase
                end
                PH_DATA:
                begin
                    acc_next        = {acc_reg[23:0], data_byte};
                    bytes_left_next = bytes_left_reg - 16'd1;
                    if (bytes_left_reg == 16'd1)
                    begin
                        finish       = 1'b1;
                        finish_value = decode_value(rec_len_reg, acc_next);
                        phase_next   = PH_HEADER;
                        hdr_idx_next = HDR_ID;
                    end
                end
                PH_SKIP:
                begin
                    bytes_left_next = bytes_left_reg - 16'd1;
                    if (bytes_left_reg == 16'd1)
                    begin
                        phase_next   = PH_HEADER;
                        hdr_idx_next = HDR_ID;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    dprm_match u_match (
        .entries     (map_entry_reg),
        .rec_id      (rec_id_reg),
        .rec_type    (rec_type_reg),
        .value       (finish_value),
        .button_last (button_last_reg),
        .result      (match)
    );

    // Parser state and last button value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            hdr_idx_reg     <= HDR_ID;
            rec_id_reg      <= '0;
            rec_type_reg    <= '0;
            rec_len_reg     <= '0;
            bytes_left_reg  <= '0;
            acc_reg         <= '0;
            button_last_reg <= '1;
        end
        else if (in_accept)
        begin
            phase_reg      <= phase_next;
            hdr_idx_reg    <= hdr_idx_next;
            rec_id_reg     <= rec_id_next;
            rec_type_reg   <= rec_type_next;
            rec_len_reg    <= rec_len_next;
            bytes_left_reg <= bytes_left_next;
            acc_reg        <= acc_next;
            if (finish && match.button_load)
            begin
                button_last_reg <= finish_value;
            end
        end
    end

    // Result valid: set on a new result, clear when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept && finish && match.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_accept && finish && match.emit)
        begin
            kind_reg   <= match.kind;
            stype_reg  <= match.stype;
            value_reg  <= match.value;
            digits_reg <= match.digits;
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_kind     = kind_reg;
    assign sensor_type    = stype_reg;
    assign sensor_value   = value_reg;
    assign decimal_digits = digits_reg;

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the datapoint record mapper: directed table, then random messages.
module tb_top
    import dprm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS       = 1900;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN       = 8;
    localparam int DIR_ROWS    = 28;

    // One output item of the block
    typedef struct packed {
        logic               kind;
        logic [7:0]         stype;
        logic signed [31:0] value;
        logic [7:0]         digits;
    } dp_event_t;

    // How a directed row is checked
    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_NONE,
        CHK_TYPED
    } chk_t;

    typedef struct packed {
        logic       start;
        logic [7:0] data;
        chk_t       chk;
        dp_event_t  ev;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [7:0] data_byte = 8'h00;
    logic message_start = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic event_kind;
    logic [7:0] sensor_type;
    logic signed [31:0] sensor_value;
    logic [7:0] decimal_digits;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = 32'h0;

    // Parser mirror: configuration and state
    logic        pe_on = 1'b0;
    map_entry_t  map_tab [MAP_ENTRIES] = '{default: '0};
    logic [1:0]  ph = PH_IDLE;
    logic [1:0]  hdr_pos = HDR_ID;
    logic [7:0]  rec_id = 8'h00;
    logic [7:0]  rec_type = 8'h00;
    logic [15:0] rec_len = 16'h0;
    logic [15:0] remain = 16'h0;
    logic [31:0] acc = 32'h0;
    logic [31:0] last_btn = 32'hFFFF_FFFF;

    dp_event_t pending_events[$];
    row_t      dir_tab [DIR_ROWS];
    int        fail_count = 0;
    int        sent_items = 0;
    int        phase_count = 0;
    int        cycles = 0;
    bit        tx_fast = 1'b0;
    bit        rx_fast = 1'b0;

    datapoint_record_mapper_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .message_start  (message_start),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_kind     (event_kind),
        .sensor_type    (sensor_type),
        .sensor_value   (sensor_value),
        .decimal_digits (decimal_digits),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Generate the clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic row_t mk(input logic st, input logic [7:0] d, input chk_t c,
                                input dp_event_t ev);
        row_t r;
        r.start = st;
        r.data  = d;
        r.chk   = c;
        r.ev    = ev;
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        fail_count++;
        $display("mismatch: %s got %h want %h at %0t", what, got, want, $time);
    endtask

    // Decode the finished record, walk the table and update the button history
    task automatic close_record(output bit hit, output dp_event_t r);
        logic [31:0] val;
        map_entry_t  e;
        bit          done;
        int          u;
        hit  = 1'b0;
        r    = '0;
        done = 1'b0;
        case (rec_len)
            16'd1:   val = {24'd0, acc[7:0]};
            16'd2:   val = {16'd0, acc[15:0]};
            16'd4:   val = acc;
            default: val = 32'd0;
        endcase
        ph      = PH_HEADER;
        hdr_pos = HDR_ID;
        for (u = 0; u < MAP_ENTRIES; u++)
        begin
            e = map_tab[u];
            if (!done)
            begin
                if (e.id == 8'h00)
                begin
                    done = 1'b1;
                end
                else if (e.id == rec_id && e.rtype == rec_type)
                begin
                    done = 1'b1;
                    if (e.stype < SENSOR_LIMIT)
                    begin
                        hit      = 1'b1;
                        r.kind   = KIND_SENSOR;
                        r.stype  = e.stype;
                        r.value  = val;
                        r.digits = e.digits;
                    end
                    else if (e.stype == BUTTON_TYPE && !val[31])
                    begin
                        // press only when a prior value exists and changed
                        if (!last_btn[31] && last_btn != val)
                        begin
                            hit    = 1'b1;
                            r.kind = KIND_BUTTON;
                        end
                        last_btn = val;
                    end
                end
            end
        end
    endtask

    // Advance the parser mirror by one accepted byte
    task automatic advance_parser(input logic [7:0] b, input logic st,
                                  output bit hit, output dp_event_t r);
        hit = 1'b0;
        r   = '0;
        if (!pe_on)
        begin
            ph      = PH_IDLE;
            hdr_pos = HDR_ID;
        end
        else if (st)
        begin
            ph      = PH_HEADER;
            hdr_pos = HDR_ID;
        end
        else
        begin
            case (ph)
                PH_HEADER:
                begin
                    case (hdr_pos)
                        HDR_ID:
                        begin
                            rec_id  = b;
                            hdr_pos = HDR_TYPE;
                        end
                        HDR_TYPE:
                        begin
                            rec_type = b;
                            hdr_pos  = HDR_LEN_HI;
                        end
                        HDR_LEN_HI:
                        begin
                            rec_len = {b, 8'h00};
                            hdr_pos = HDR_LEN_LO;
                        end
                        default:
                        begin
                            rec_len = {rec_len[15:8], b};
                            hdr_pos = HDR_ID;
                            acc     = 32'h0;
                            remain  = rec_len;
                            if (rec_len == 16'd0)
                            begin
                                close_record(hit, r);
                            end
                            else
                            begin
                                ph = (rec_len > MAX_VALUE_BYTES) ? PH_SKIP : PH_DATA;
                            end
                        end
                    endcase
                end
                PH_DATA:
                begin
                    acc    = {acc[23:0], b};
                    remain = remain - 16'd1;
                    if (remain == 16'd0)
                    begin
                        close_record(hit, r);
                    end
                end
                PH_SKIP:
                begin
                    remain = remain - 16'd1;
                    if (remain == 16'd0)
                    begin
                        ph      = PH_HEADER;
                        hdr_pos = HDR_ID;
                    end
                end
                default:
                begin
                    ph = PH_IDLE;
                end
            endcase
        end
    endtask

    // Offer one byte; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic st, input chk_t c,
                             input dp_event_t ev);
        int        gap;
        bit        hit;
        dp_event_t r;
        if ($urandom_range(0, 39) == 0)
        begin
            tx_fast = !tx_fast;
        end
        gap = tx_fast ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        message_start <= st;
        do @(posedge clk); while (!(in_valid && in_ready));
        phase_count++;
        if (pe_on)
        begin
            sent_items++;
        end
        advance_parser(b, st, hit, r);
        case (c)
            CHK_PREDICT:
            begin
                if (hit)
                begin
                    pending_events.push_back(r);
                end
            end
            CHK_TYPED:
            begin
                pending_events.push_back(ev);
            end
            default:
            begin
            end
        endcase
        @(negedge clk);
    endtask

    // Write one register; the caller drops cfg_valid after the last write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        if (idx == REG_PARSE_ENABLE)
        begin
            pe_on = val[0];
        end
        else if (idx >= REG_MAP_BASE && idx < REG_MAP_BASE + MAP_ENTRIES)
        begin
            map_tab[idx - REG_MAP_BASE] = val;
        end
        @(negedge clk);
    endtask

    // Wait until every expected item has arrived and the block has gone quiet
    task automatic settle();
        while (pending_events.size() != 0) @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    // Load a fresh table and enable setting for one phase
    task automatic setup_phase(input int p);
        logic [31:0] ent;
        logic [7:0]  st;
        int          u;
        int          r;
        write_reg(REG_PARSE_ENABLE, ($urandom() & ~32'h1) | ((p == 3) ? 32'h0 : 32'h1));
        for (u = 0; u < MAP_ENTRIES; u++)
        begin
            r = $urandom_range(0, 9);
            if (r < 5)
            begin
                st = 8'($urandom_range(0, SENSOR_LIMIT - 1));
            end
            else if (r < 8)
            begin
                st = BUTTON_TYPE;
            end
            else if (r == 8)
            begin
                st = 8'($urandom_range(SENSOR_LIMIT, 255));
            end
            else
            begin
                st = SENSOR_LIMIT - 8'd1;
            end
            ent = {8'($urandom_range(1, 255)), 8'($urandom()), st, 8'($urandom())};
            // repeat the id and type of the previous entry so first match wins
            if (u > 0 && $urandom_range(0, 5) == 0)
            begin
                ent[31:16] = {map_tab[u - 1].id, map_tab[u - 1].rtype};
            end
            if ($urandom_range(0, 15) == 0)
            begin
                ent[31:24] = 8'h00;
            end
            if (p == 1)
            begin
                ent = 32'hFFFF_FFFF;
            end
            else if (p == 5)
            begin
                ent = 32'h0;
            end
            write_reg(CFG_INDEX_W'(REG_MAP_BASE + u), ent);
        end
        // an index past the table must be dropped
        write_reg(CFG_INDEX_W'($urandom_range(REG_MAP_BASE + MAP_ENTRIES,
                                              (1 << CFG_INDEX_W) - 1)), $urandom());
        cfg_valid <= 1'b0;
    endtask

    // Send one record, whole or cut short; cut tells the caller to end the message
    task automatic send_record(output bit cut);
        logic [7:0]  rec_q[$];
        map_entry_t  pick;
        logic [15:0] len;
        int          nd;
        int          keep;
        int          i;
        int          r;
        if ($urandom_range(0, 3) != 0)
        begin
            pick = map_tab[$urandom_range(0, MAP_ENTRIES - 1)];
        end
        else
        begin
            pick = $urandom();
        end
        r = $urandom_range(0, 15);
        if (r < 11)
        begin
            len = 16'($urandom_range(0, 4));
        end
        else if (r < 14)
        begin
            len = 16'($urandom_range(5, 12));
        end
        else
        begin
            len = 16'($urandom());
        end
        rec_q = '{pick.id, pick.rtype, len[15:8], len[7:0]};
        nd = (len > 12) ? $urandom_range(0, 6) : int'(len);
        for (i = 0; i < nd; i++)
        begin
            rec_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom()));
        end
        cut  = (len > 12) || ($urandom_range(0, 11) == 0);
        keep = (cut && len <= 12) ? $urandom_range(1, rec_q.size() - 1) : rec_q.size();
        for (i = 0; i < keep; i++)
        begin
            send_byte(rec_q[i], 1'b0, CHK_PREDICT, '0);
        end
    endtask

    // Compare each accepted output item with the oldest expectation
    always @(posedge clk)
    begin
        dp_event_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_events.size() == 0)
            begin
                report("item with nothing pending", {31'd0, event_kind}, 32'd0);
            end
            else
            begin
                e = pending_events.pop_front();
                if (event_kind !== e.kind)
                begin
                    report("event_kind", {31'd0, event_kind}, {31'd0, e.kind});
                end
                if (sensor_type !== e.stype)
                begin
                    report("sensor_type", {24'd0, sensor_type}, {24'd0, e.stype});
                end
                if (sensor_value !== e.value)
                begin
                    report("sensor_value", sensor_value, e.value);
                end
                if (decimal_digits !== e.digits)
                begin
                    report("decimal_digits", {24'd0, decimal_digits}, {24'd0, e.digits});
                end
            end
        end
    end

    // Receiver: stall a random number of cycles before each item
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 39) == 0)
            begin
                rx_fast = !rx_fast;
            end
            stall = rx_fast ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid === 1'b1 && out_ready));
        end
    end

    // Watchdog
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_top: errors");
        $finish;
    end

    // Stimulus
    initial
    begin
        int  p;
        int  target;
        int  i;
        int  n;
        bit  cut;
        int  k;
        int  nrec;
        dir_tab = '{
            mk(1'b0, 8'h5A, CHK_NONE, '0),      // stray byte before any message
            mk(1'b1, 8'hFF, CHK_NONE, '0),      // flags byte
            mk(1'b0, 8'h01, CHK_PREDICT, '0),
            mk(1'b0, 8'h02, CHK_PREDICT, '0),
            mk(1'b0, 8'h00, CHK_PREDICT, '0),
            mk(1'b0, 8'h00, CHK_TYPED, {KIND_SENSOR, 8'h00, 32'h0, 8'hFF}),  // zero length
            mk(1'b0, 8'hFF, CHK_PREDICT, '0),
            mk(1'b0, 8'hFF, CHK_PREDICT, '0),
            mk(1'b0, 8'h00, CHK_PREDICT, '0),
            mk(1'b0, 8'h04, CHK_PREDICT, '0),
            mk(1'b0, 8'h80, CHK_PREDICT, '0),
            mk(1'b0, 8'h00, CHK_PREDICT, '0),
            mk(1'b0, 8'h00, CHK_PREDICT, '0),
            mk(1'b0, 8'h00, CHK_TYPED, {KIND_SENSOR, 8'hEF, 32'h8000_0000, 8'h00}),
            mk(1'b0, 8'h03, CHK_PREDICT, '0),   // first button value, no press
            mk(1'b0, 8'h04, CHK_PREDICT, '0),
            mk(1'b0, 8'h00, CHK_PREDICT, '0),
            mk(1'b0, 8'h00, CHK_PREDICT, '0),
            mk(1'b0, 8'h03, CHK_PREDICT, '0),
            mk(1'b0, 8'h04, CHK_PREDICT, '0),
            mk(1'b0, 8'h00, CHK_PREDICT, '0),
            mk(1'b0, 8'h01, CHK_PREDICT, '0),
            mk(1'b0, 8'h7F, CHK_TYPED, {KIND_BUTTON, 8'h00, 32'h0, 8'h00}),
            mk(1'b0, 8'h01, CHK_PREDICT, '0),   // longest record, skipped
            mk(1'b0, 8'h02, CHK_PREDICT, '0),
            mk(1'b0, 8'hFF, CHK_PREDICT, '0),
            mk(1'b0, 8'hFF, CHK_PREDICT, '0),
            mk(1'b1, 8'h00, CHK_PREDICT, '0)    // new message cuts the skip short
        };

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table setup
        write_reg(REG_PARSE_ENABLE, 32'h1);
        write_reg(CFG_INDEX_W'(REG_MAP_BASE + 0), 32'h0102_00FF);
        write_reg(CFG_INDEX_W'(REG_MAP_BASE + 1), 32'hFFFF_EF00);
        write_reg(CFG_INDEX_W'(REG_MAP_BASE + 2), 32'h0304_FE12);
        write_reg(CFG_INDEX_W'(REG_MAP_BASE + 3), 32'h0506_F000);
        cfg_valid <= 1'b0;

        for (i = 0; i < DIR_ROWS; i++)
        begin
            send_byte(dir_tab[i].data, dir_tab[i].start, dir_tab[i].chk, dir_tab[i].ev);
        end
        in_valid <= 1'b0;

        // Random phases, each with its own table
        for (p = 0; sent_items < ITEMS; p++)
        begin
            settle();
            setup_phase(p);
            if (p == 3)
            begin
                target = 60;
            end
            else if (p == 1 || p == 5)
            begin
                target = 80;
            end
            else
            begin
                target = 260;
            end
            phase_count = 0;
            while (phase_count < target)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // noise: loose bytes, now and then a bare start
                    n = $urandom_range(1, 3);
                    for (k = 0; k < n; k++)
                    begin
                        send_byte(8'($urandom()), ($urandom_range(0, 7) == 0),
                                  CHK_PREDICT, '0);
                    end
                end
                else
                begin
                    send_byte(8'($urandom()), 1'b1, CHK_PREDICT, '0);
                    nrec = $urandom_range(1, 4);
                    cut  = 1'b0;
                    for (k = 0; k < nrec && !cut; k++)
                    begin
                        send_record(cut);
                    end
                end
            end
            in_valid <= 1'b0;
        end

        settle();
        if (fail_count == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
